>>> rtl/assert_macros.svh
// Assertion macros shared by the date stream gap tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CHECK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

>>> rtl/dsgt_pkg.sv
// Types, constants and date arithmetic helpers for the date stream gap tracker.
package dsgt_pkg;

   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int CNT_W   = 16;
   localparam int LEAPS_W = 10;
   localparam int SUM_W   = 22;

   localparam int YEAR_SPAN = 128;
   localparam logic [YEAR_W-1:0] EPOCH_RESET = 12'd2010;
   localparam logic [CNT_W-1:0]  CNT_MAX     = '1;
   localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
   localparam logic [DAY_W-1:0]  FEB_LEAP_LEN = 5'd29;

   typedef enum logic [1:0] {
      ST_FIRST   = 2'd0,
      ST_GAP     = 2'd1,
      ST_INVALID = 2'd2,
      ST_EARLIER = 2'd3
   } status_type;

   typedef struct packed {
      logic             ok;
      logic [CNT_W-1:0] day_number;
   } date_info_type;

   // Month length (non-leap), zero for codes that are not months.
   localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
      5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
      5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
   };

   // Days before the first of each month in a non-leap year.
   localparam logic [8:0] MONTH_START [16] = '{
      9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0, 9'd0, 9'd0
   };

   // floor(x / 100) = floor(floor(x / 4) / 25), reciprocal 1311 / 2^15.
   function automatic logic [5:0] div100(input logic [YEAR_W-1:0] x);
      logic [20:0] prod;
      prod = 21'(x[YEAR_W-1:2]) * 21'd1311;
      return prod[20:15];
   endfunction

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [5:0] hund;
      logic [9:0] quarter;
      hund    = div100(y);
      quarter = y[YEAR_W-1:2];
      return (y[1:0] == 2'b00) &&
             ((quarter != 10'(10'(hund) * 10'd25)) || (y[3:2] == 2'b00));
   endfunction

   // Leap years in [0, n).
   function automatic logic [LEAPS_W-1:0] leaps_before(input logic [YEAR_W-1:0] n);
      logic [YEAR_W-1:0]  m;
      logic [5:0]         hund;
      logic [LEAPS_W-1:0] res;
      m    = n - 12'd1;
      hund = div100(m);
      if (n == '0) begin
         res = '0;
      end else begin
         res = 10'(m[YEAR_W-1:2]) - 10'(hund) + 10'(hund[5:2]) + 10'd1;
      end
      return res;
   endfunction

endpackage

>>> rtl/dsgt_req_if.sv
// Request channel: one calendar date per transfer.
interface dsgt_req_if;
   logic                          valid;
   logic                          ready;
   logic [dsgt_pkg::YEAR_W-1:0]   year;
   logic [dsgt_pkg::MONTH_W-1:0]  month;
   logic [dsgt_pkg::DAY_W-1:0]    day;

   modport source (output valid, year, month, day, input ready);
   modport sink   (input valid, year, month, day, output ready);
endinterface

>>> rtl/dsgt_rsp_if.sv
// Response channel: status, day number, gap and running statistics.
interface dsgt_rsp_if;
   logic                        valid;
   logic                        ready;
   dsgt_pkg::status_type        status;
   logic [dsgt_pkg::CNT_W-1:0]  day_number;
   logic [dsgt_pkg::CNT_W-1:0]  gap_days;
   logic [dsgt_pkg::CNT_W-1:0]  valid_total;
   logic [dsgt_pkg::CNT_W-1:0]  invalid_total;
   logic [dsgt_pkg::CNT_W-1:0]  shortest_gap;
   logic [dsgt_pkg::CNT_W-1:0]  longest_gap;
   logic [dsgt_pkg::CNT_W-1:0]  gap_sum;

   modport source (output valid, status, day_number, gap_days, valid_total, invalid_total,
                   shortest_gap, longest_gap, gap_sum, input ready);
   modport sink   (input valid, status, day_number, gap_days, valid_total, invalid_total,
                   shortest_gap, longest_gap, gap_sum, output ready);
endinterface

>>> rtl/dsgt_date_conv.sv
// Date check and conversion to a one-based day number from the epoch.
module dsgt_date_conv (
   input  logic [dsgt_pkg::YEAR_W-1:0]  year,
   input  logic [dsgt_pkg::MONTH_W-1:0] month,
   input  logic [dsgt_pkg::DAY_W-1:0]   day,
   input  logic [dsgt_pkg::YEAR_W-1:0]  epoch_year,
   input  logic [dsgt_pkg::LEAPS_W-1:0] epoch_leaps,
   output dsgt_pkg::date_info_type      info
);

   logic                          leap;
   logic [dsgt_pkg::YEAR_W-1:0]   span;
   logic                          in_range;
   logic [dsgt_pkg::DAY_W-1:0]    mlen;
   logic                          day_ok;
   logic                          ok;
   logic [dsgt_pkg::SUM_W-1:0]    n;

   assign leap     = dsgt_pkg::is_leap(year);
   assign span     = year - epoch_year;
   assign in_range = (year >= epoch_year) && (span < 12'(dsgt_pkg::YEAR_SPAN));
   assign mlen     = (month == dsgt_pkg::FEBRUARY && leap) ? dsgt_pkg::FEB_LEAP_LEN
                                                          : dsgt_pkg::MONTH_LEN[month];
   assign day_ok   = (day != '0) && (day <= mlen);
   assign ok       = in_range && day_ok;

   assign n = 22'(day) + 22'(dsgt_pkg::MONTH_START[month])
            + 22'(leap && (month > dsgt_pkg::FEBRUARY))
            + 22'(span) * 22'd365
            + 22'(dsgt_pkg::leaps_before(year)) - 22'(epoch_leaps);

   always_comb begin
      info.ok = ok;
      if (!ok) begin
         info.day_number = '0;
      end else if (n > 22'(dsgt_pkg::CNT_MAX)) begin
         info.day_number = dsgt_pkg::CNT_MAX;
      end else begin
         info.day_number = n[dsgt_pkg::CNT_W-1:0];
      end
   end

endmodule

>>> rtl/date_stream_gap_tracker_core.sv
// Top level: date stream gap tracker with request register, statistics and response register.
// A request passes the request register, then the response register. Throughput: one request
// per cycle while the response side is ready; the response register frees the request stage.
// The date conversion sits ahead of the request register; statistics logic is combinational.
// Reset (synchronous, active high) clears all statistics and sets epoch_year to 2010.
`include "assert_macros.svh"

module date_stream_gap_tracker_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [dsgt_pkg::YEAR_W-1:0] csr_wdata,
   dsgt_req_if.sink                    req_chan,
   dsgt_rsp_if.source                  rsp_chan
);

   localparam int W = dsgt_pkg::CNT_W;

   logic [dsgt_pkg::YEAR_W-1:0]  epoch_year_ff;
   logic [dsgt_pkg::LEAPS_W-1:0] epoch_leaps_ff;

   dsgt_pkg::date_info_type conv_info;
   dsgt_pkg::date_info_type s1_info_ff;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    req_fire, advance;

   logic [W-1:0] last_dn_ff, last_dn_in;
   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] rej_ff, rej_in;
   logic [W-1:0] min_ff, min_in;
   logic [W-1:0] max_ff, max_in;
   logic [W-1:0] sum_ff, sum_in;

   dsgt_pkg::status_type status_in, status_ff;
   logic [W-1:0]         dn_in, dn_ff;
   logic [W-1:0]         gap_in, gap_ff;
   logic [W:0]           sum_wide;

   dsgt_date_conv u_conv (
      .year        (req_chan.year),
      .month       (req_chan.month),
      .day         (req_chan.day),
      .epoch_year  (epoch_year_ff),
      .epoch_leaps (epoch_leaps_ff),
      .info        (conv_info)
   );

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // statistics update for the request in the request register
   always_comb begin
      last_dn_in = last_dn_ff;
      acc_in     = acc_ff;
      rej_in     = rej_ff;
      min_in     = min_ff;
      max_in     = max_ff;
      sum_in     = sum_ff;
      dn_in      = s1_info_ff.day_number;
      gap_in     = '0;
      status_in  = dsgt_pkg::ST_GAP;
      sum_wide   = (W+1)'(sum_ff) + (W+1)'(s1_info_ff.day_number - last_dn_ff);
      if (!s1_info_ff.ok) begin
         status_in = dsgt_pkg::ST_INVALID;
         dn_in     = '0;
         rej_in    = (rej_ff == dsgt_pkg::CNT_MAX) ? rej_ff : rej_ff + 1'b1;
      end else if (acc_ff != '0 && s1_info_ff.day_number < last_dn_ff) begin
         status_in = dsgt_pkg::ST_EARLIER;
         rej_in    = (rej_ff == dsgt_pkg::CNT_MAX) ? rej_ff : rej_ff + 1'b1;
      end else if (acc_ff == '0) begin
         status_in  = dsgt_pkg::ST_FIRST;
         acc_in     = W'(1);
         last_dn_in = s1_info_ff.day_number;
      end else begin
         gap_in = s1_info_ff.day_number - last_dn_ff;
         if (acc_ff == W'(1)) begin
            min_in = gap_in;
            max_in = gap_in;
         end else begin
            if (gap_in < min_ff) begin
               min_in = gap_in;
            end
            if (gap_in > max_ff) begin
               max_in = gap_in;
            end
         end
         sum_in     = sum_wide[W] ? dsgt_pkg::CNT_MAX : sum_wide[W-1:0];
         acc_in     = (acc_ff == dsgt_pkg::CNT_MAX) ? acc_ff : acc_ff + 1'b1;
         last_dn_in = s1_info_ff.day_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_year_ff  <= dsgt_pkg::EPOCH_RESET;
         epoch_leaps_ff <= dsgt_pkg::leaps_before(dsgt_pkg::EPOCH_RESET);
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_dn_ff     <= '0;
         acc_ff         <= '0;
         rej_ff         <= '0;
         min_ff         <= '0;
         max_ff         <= '0;
         sum_ff         <= '0;
      end else begin
         if (csr_we) begin
            epoch_year_ff  <= csr_wdata;
            epoch_leaps_ff <= dsgt_pkg::leaps_before(csr_wdata);
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            last_dn_ff <= last_dn_in;
            acc_ff     <= acc_in;
            rej_ff     <= rej_in;
            min_ff     <= min_in;
            max_ff     <= max_in;
            sum_ff     <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_info_ff <= conv_info;
      end
      if (advance) begin
         status_ff <= status_in;
         dn_ff     <= dn_in;
         gap_ff    <= gap_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.day_number    = dn_ff;
   assign rsp_chan.gap_days      = gap_ff;
   assign rsp_chan.valid_total   = acc_ff;
   assign rsp_chan.invalid_total = rej_ff;
   assign rsp_chan.shortest_gap  = min_ff;
   assign rsp_chan.longest_gap   = max_ff;
   assign rsp_chan.gap_sum       = sum_ff;

   `ASSERT_CHECK(a_first_once, clock, reset, (rsp_valid_ff && status_ff == dsgt_pkg::ST_FIRST) |-> (acc_ff == W'(1)))
   `ASSERT_CHECK(a_invalid_zero, clock, reset, (rsp_valid_ff && status_ff == dsgt_pkg::ST_INVALID) |-> (dn_ff == '0))
   `ASSERT_CHECK(a_gap_status, clock, reset, (rsp_valid_ff && gap_ff != '0) |-> (status_ff == dsgt_pkg::ST_GAP))
   `ASSERT_NEVER(a_min_max_order, clock, reset, min_ff > max_ff)
   `ASSERT_CHECK(a_advance_rsp, clock, reset, advance |=> rsp_valid_ff)

endmodule

>>> dv/dsgt_gap_checker.sv
// Checker for the date stream gap tracker: predicts every response and compares it.
`timescale 1ns / 100ps

module dsgt_gap_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [dsgt_pkg::YEAR_W-1:0] csr_wdata,
   dsgt_req_if                         req_mon,
   dsgt_rsp_if                         rsp_mon,
   output int                          mismatch_count,
   output int                          results_seen
);

   typedef struct packed {
      dsgt_pkg::status_type       status;
      logic [dsgt_pkg::CNT_W-1:0] day_number;
      logic [dsgt_pkg::CNT_W-1:0] gap_days;
      logic [dsgt_pkg::CNT_W-1:0] valid_total;
      logic [dsgt_pkg::CNT_W-1:0] invalid_total;
      logic [dsgt_pkg::CNT_W-1:0] shortest_gap;
      logic [dsgt_pkg::CNT_W-1:0] longest_gap;
      logic [dsgt_pkg::CNT_W-1:0] gap_sum;
   } date_result_type;

   int unsigned     epoch;
   int unsigned     last_dn;
   int unsigned     n_accepted;
   int unsigned     n_rejected;
   int unsigned     gap_min;
   int unsigned     gap_max;
   int unsigned     gap_total;
   int              fail_tally;
   int              seen_tally;
   date_result_type expected_results [$];

   function automatic bit leap_year(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // leap years in [0, n)
   function automatic int unsigned leaps_below(int unsigned n);
      int unsigned m;
      if (n == 0) begin
         return 0;
      end
      m = n - 1;
      return m / 4 - m / 100 + m / 400 + 1;
   endfunction

   function automatic int unsigned month_length(int unsigned m, int unsigned y);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap_year(y) ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic int unsigned bump(int unsigned v);
      return (v < dsgt_pkg::CNT_MAX) ? v + 1 : dsgt_pkg::CNT_MAX;
   endfunction

   // Converts one date and advances the running statistics.
   function automatic date_result_type track_date(int unsigned y, int unsigned m,
                                                  int unsigned d);
      date_result_type r;
      int unsigned     days;
      int unsigned     gap;
      bit              ok;
      r  = '0;
      ok = (y >= epoch) && (y - epoch < dsgt_pkg::YEAR_SPAN) && (d >= 1)
           && (d <= month_length(m, y));
      if (!ok) begin
         r.status   = dsgt_pkg::ST_INVALID;
         n_rejected = bump(n_rejected);
      end else begin
         days = d + 365 * (y - epoch) + leaps_below(y) - leaps_below(epoch);
         for (int unsigned i = 1; i < m; i++) begin
            days += month_length(i, y);
         end
         if (days > dsgt_pkg::CNT_MAX) begin
            days = dsgt_pkg::CNT_MAX;
         end
         r.day_number = dsgt_pkg::CNT_W'(days);
         if (n_accepted != 0 && days < last_dn) begin
            r.status   = dsgt_pkg::ST_EARLIER;
            n_rejected = bump(n_rejected);
         end else if (n_accepted == 0) begin
            r.status   = dsgt_pkg::ST_FIRST;
            n_accepted = 1;
            last_dn    = days;
         end else begin
            r.status   = dsgt_pkg::ST_GAP;
            gap        = days - last_dn;
            r.gap_days = dsgt_pkg::CNT_W'(gap);
            if (n_accepted == 1) begin
               gap_min = gap;
               gap_max = gap;
            end else begin
               if (gap < gap_min) begin
                  gap_min = gap;
               end
               if (gap > gap_max) begin
                  gap_max = gap;
               end
            end
            gap_total  = (gap_total + gap > dsgt_pkg::CNT_MAX) ? dsgt_pkg::CNT_MAX
                                                               : gap_total + gap;
            n_accepted = bump(n_accepted);
            last_dn    = days;
         end
      end
      r.valid_total   = dsgt_pkg::CNT_W'(n_accepted);
      r.invalid_total = dsgt_pkg::CNT_W'(n_rejected);
      r.shortest_gap  = dsgt_pkg::CNT_W'(gap_min);
      r.longest_gap   = dsgt_pkg::CNT_W'(gap_max);
      r.gap_sum       = dsgt_pkg::CNT_W'(gap_total);
      return r;
   endfunction

   function automatic string show(date_result_type r);
      return $sformatf("status %0d day %0d gap %0d valid %0d invalid %0d min %0d max %0d sum %0d",
                       r.status, r.day_number, r.gap_days, r.valid_total, r.invalid_total,
                       r.shortest_gap, r.longest_gap, r.gap_sum);
   endfunction

   always @(posedge clock) begin
      date_result_type want;
      date_result_type got;
      string           wrong;
      if (reset) begin
         epoch      = dsgt_pkg::EPOCH_RESET;
         last_dn    = 0;
         n_accepted = 0;
         n_rejected = 0;
         gap_min    = 0;
         gap_max    = 0;
         gap_total  = 0;
         fail_tally = 0;
         seen_tally = 0;
         expected_results.delete();
      end else begin
         if (csr_we) begin
            epoch = csr_wdata;
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status        = rsp_mon.status;
            got.day_number    = rsp_mon.day_number;
            got.gap_days      = rsp_mon.gap_days;
            got.valid_total   = rsp_mon.valid_total;
            got.invalid_total = rsp_mon.invalid_total;
            got.shortest_gap  = rsp_mon.shortest_gap;
            got.longest_gap   = rsp_mon.longest_gap;
            got.gap_sum       = rsp_mon.gap_sum;
            seen_tally++;
            if (expected_results.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10) begin
                  $display("response %0d with no request pending: %s", seen_tally, show(got));
               end
            end else begin
               want  = expected_results.pop_front();
               wrong = "";
               if (got.status !== want.status) wrong = {wrong, " status"};
               if (got.day_number !== want.day_number) wrong = {wrong, " day_number"};
               if (got.gap_days !== want.gap_days) wrong = {wrong, " gap_days"};
               if (got.valid_total !== want.valid_total) wrong = {wrong, " valid_total"};
               if (got.invalid_total !== want.invalid_total) wrong = {wrong, " invalid_total"};
               if (got.shortest_gap !== want.shortest_gap) wrong = {wrong, " shortest_gap"};
               if (got.longest_gap !== want.longest_gap) wrong = {wrong, " longest_gap"};
               if (got.gap_sum !== want.gap_sum) wrong = {wrong, " gap_sum"};
               if (wrong != "") begin
                  fail_tally++;
                  if (fail_tally <= 10) begin
                     $display("response %0d mismatch in%s\n  expected %s\n  actual   %s",
                              seen_tally, wrong, show(want), show(got));
                  end
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(track_date(req_mon.year, req_mon.month, req_mon.day));
         end
      end
      mismatch_count <= fail_tally;
      results_seen   <= seen_tally;
   end

endmodule

>>> dv/testbench.sv
// Testbench top for the date stream gap tracker: clock, reset, date requests and verdict.
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned YEAR_TOP = (1 << dsgt_pkg::YEAR_W) - 1;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        csr_we;
   logic [dsgt_pkg::YEAR_W-1:0] csr_wdata;
   int                          mismatch_count;
   int                          results_seen;
   int                          dates_sent     = 0;
   int                          burst_left     = 0;
   bit                          long_hold_done = 1'b0;
   int unsigned                 base_year;
   int unsigned                 cur_year;
   int unsigned                 cur_month;
   int unsigned                 cur_day;

   dsgt_req_if req_bus ();
   dsgt_rsp_if rsp_bus ();

   date_stream_gap_tracker_core u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   dsgt_gap_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .results_seen   (results_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("testbench NOT OK");
      $finish;
   end

   function automatic int unsigned days_of(int unsigned m, int unsigned y);
      case (m)
         4, 6, 9, 11: return 30;
         2:           return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   function automatic int unsigned last_year();
      return (base_year + dsgt_pkg::YEAR_SPAN - 1 > YEAR_TOP) ? YEAR_TOP
                                                              : base_year + dsgt_pkg::YEAR_SPAN - 1;
   endfunction

   function automatic void keep_cursor_in_span();
      if (cur_year > last_year()) begin
         cur_year = $urandom_range(last_year(), base_year);
      end
      if (cur_day > days_of(cur_month, cur_year)) begin
         cur_day = days_of(cur_month, cur_year);
      end
   endfunction

   // response side: random stalls, ready bursts and one long hold-off
   initial begin : rsp_stall
      int pick;
      int span_len;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         pick = $urandom_range(99);
         if (!long_hold_done && dates_sent >= 400) begin
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            span_len = 120;
         end else if (pick < 60) begin
            rsp_bus.ready <= 1'b1;
            span_len = $urandom_range(8, 1);
         end else if (pick < 75) begin
            rsp_bus.ready <= 1'b1;
            span_len = $urandom_range(60, 20);
         end else if (pick < 95) begin
            rsp_bus.ready <= 1'b0;
            span_len = $urandom_range(3, 1);
         end else begin
            rsp_bus.ready <= 1'b0;
            span_len = $urandom_range(40, 10);
         end
         repeat (span_len) @(posedge clock);
      end
   end

   task automatic put_date(input int unsigned y, input int unsigned m, input int unsigned d);
      int pick;
      int idle;
      pick = $urandom_range(99);
      idle = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else if (pick < 4) begin
         burst_left = $urandom_range(60, 20);
      end else if (pick >= 70 && pick < 94) begin
         idle = $urandom_range(3, 1);
      end else if (pick >= 94) begin
         idle = $urandom_range(30, 8);
      end
      if (idle > 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.year  <= dsgt_pkg::YEAR_W'(y);
      req_bus.month <= dsgt_pkg::MONTH_W'(m);
      req_bus.day   <= dsgt_pkg::DAY_W'(d);
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      dates_sent++;
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (results_seen < dates_sent) @(posedge clock);
   endtask

   // cursor keeps its offset from the epoch so day numbers keep climbing
   task automatic write_epoch(input int unsigned e);
      int unsigned offset;
      wait_idle();
      offset = cur_year - base_year;
      csr_we    <= 1'b1;
      csr_wdata <= dsgt_pkg::YEAR_W'(e);
      @(posedge clock);
      csr_we    <= 1'b0;
      base_year = e;
      cur_year  = e + offset;
      keep_cursor_in_span();
   endtask

   task automatic put_random_date();
      int          pick;
      int          kind;
      int unsigned steps;
      int unsigned y;
      int unsigned m;
      int unsigned d;
      pick = $urandom_range(99);
      if (pick < 65) begin
         kind = $urandom_range(99);
         if (kind < 20) begin
            steps = 0;
         end else if (kind < 70) begin
            steps = $urandom_range(5, 1);
         end else if (kind < 90) begin
            steps = $urandom_range(60, 6);
         end else begin
            steps = $urandom_range(400, 61);
         end
         cur_day += steps;
         while (cur_day > days_of(cur_month, cur_year)) begin
            cur_day -= days_of(cur_month, cur_year);
            if (cur_month == 12) begin
               cur_month = 1;
               cur_year++;
            end else begin
               cur_month++;
            end
         end
         keep_cursor_in_span();
         put_date(cur_year, cur_month, cur_day);
      end else if (pick < 75) begin
         y = $urandom_range(last_year(), base_year);
         m = $urandom_range(12, 1);
         put_date(y, m, $urandom_range(days_of(m, y), 1));
      end else if (pick < 87) begin
         y = cur_year;
         m = cur_month;
         d = cur_day;
         case ($urandom_range(3))
            0: m = $urandom_range(1) ? 0 : $urandom_range(15, 13);
            1: d = 0;
            2: d = (days_of(m, y) == 31) ? 0 : $urandom_range(31, days_of(m, y) + 1);
            default: begin
               if (base_year > 0 && (last_year() == YEAR_TOP || $urandom_range(1))) begin
                  y = $urandom_range(base_year - 1, 0);
               end else begin
                  y = $urandom_range(YEAR_TOP, last_year() + 1);
               end
            end
         endcase
         put_date(y, m, d);
      end else begin
         put_date($urandom_range(YEAR_TOP), $urandom_range(15), $urandom_range(31));
      end
   endtask

   task automatic run_phase(input int unsigned e, input int count);
      write_epoch(e);
      repeat (count) put_random_date();
   endtask

   initial begin
      reset         <= 1'b1;
      csr_we        <= 1'b0;
      csr_wdata     <= '0;
      req_bus.valid <= 1'b0;
      req_bus.year  <= '0;
      req_bus.month <= '0;
      req_bus.day   <= '0;
      base_year = dsgt_pkg::EPOCH_RESET;
      cur_year  = dsgt_pkg::EPOCH_RESET;
      cur_month = 1;
      cur_day   = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      put_date(2009, 1, 1);      // before epoch, nothing accepted yet
      put_date(2010, 1, 1);      // first date, day one
      put_date(2010, 1, 1);      // same date, zero gap
      put_date(2010, 1, 31);
      put_date(2010, 2, 29);     // not a leap year
      put_date(2012, 2, 29);
      put_date(2010, 6, 15);     // earlier than last
      put_date(2012, 0, 10);
      put_date(2012, 13, 1);
      put_date(YEAR_TOP, 15, 31);
      put_date(0, 0, 0);
      put_date(2012, 3, 0);
      put_date(2012, 4, 31);
      put_date(2012, 4, 30);
      put_date(2100, 2, 29);     // century, not leap
      put_date(2138, 1, 1);      // past the span
      write_epoch(0);
      put_date(0, 2, 29);        // year zero is leap
      put_date(0, 12, 31);
      put_date(128, 1, 1);
      write_epoch(1900);
      put_date(1900, 2, 29);
      put_date(1900, 3, 1);
      write_epoch(1996);
      put_date(2000, 2, 29);     // leap by the 400 rule
      cur_year  = 2000;
      cur_month = 2;
      cur_day   = 29;

      run_phase(2010, 250);
      run_phase(1, 200);
      run_phase(3968, 200);
      run_phase(1582, 180);
      run_phase($urandom_range(4094, 2), 150);
      run_phase(YEAR_TOP, 50);
      run_phase(0, 50);

      write_epoch(dsgt_pkg::EPOCH_RESET);
      put_date(2137, 12, 31);    // last year of the span
      put_date(2138, 1, 1);

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_seen == dates_sent) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl
rtl/dsgt_pkg.sv
rtl/dsgt_req_if.sv
rtl/dsgt_rsp_if.sv
rtl/dsgt_date_conv.sv
rtl/date_stream_gap_tracker_core.sv
dv/dsgt_gap_checker.sv
dv/testbench.sv
